@@ design/fud_pkg.sv @@
package fud_pkg;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_SECT   = 3'd1,
		PH_CLEN   = 3'd2,
		PH_PARAM  = 3'd3,
		PH_IQ     = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		K_HEADER  = 3'd0,
		K_SECTHDR = 3'd1,
		K_CLEN    = 3'd2,
		K_PARAM   = 3'd3,
		K_IQ      = 3'd4,
		K_SDONE   = 3'd5,
		K_STATUS  = 3'd6
	} kind_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_PARTIAL  = 3'd1;
	localparam logic [2:0] ST_NOSECT   = 3'd2;
	localparam logic [2:0] ST_SHORT    = 3'd3;
	localparam logic [2:0] ST_REJECTED = 3'd4;

	localparam logic [2:0] REG_DIR     = 3'd0;
	localparam logic [2:0] REG_VER     = 3'd1;
	localparam logic [2:0] REG_FMASK   = 3'd2;
	localparam logic [2:0] REG_SYMCNT  = 3'd3;
	localparam logic [2:0] REG_FULLPRB = 3'd4;
	localparam logic [2:0] REG_SWIDTH  = 3'd5;
	localparam logic [2:0] REG_CPARAM  = 3'd6;
	localparam logic [2:0] REG_CLEN    = 3'd7;

	localparam int OUT_W = 81;

	// One result item; packing order follows the master tdata/tlast layout.
	typedef struct packed {
		logic        last_of_run;
		logic [3:0]  filter_number;
		logic [15:0] value;
		logic [8:0]  prb_total;
		logic [9:0]  first_prb;
		logic [1:0]  section_flags;
		logic [11:0] section_number;
		logic [5:0]  symbol_number;
		logic [5:0]  slot_number;
		logic [3:0]  subframe_number;
		logic [7:0]  frame_number;
		logic [2:0]  kind;
	} result_t;

	typedef struct packed {
		logic        dir;
		logic [2:0]  ver;
		logic [15:0] fmask;
		logic [6:0]  symcnt;
		logic [8:0]  fullprb;
		logic [5:0]  iqbytes;
		logic        cparam;
		logic        clen;
	} cfg_t;

	// Up to three results produced by one byte.
	typedef struct packed {
		logic [1:0] count;
		result_t    r2;
		result_t    r1;
		result_t    r0;
	} bundle_t;

endpackage

@@ design/fud_front.sv @@
module fud_front
	import fud_pkg::*;
#(
	parameter int MAX_PRB_COUNT = 275
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_fire,
	input  logic [7:0] b,
	input  logic    eom,
	input  cfg_t    cfg,
	output bundle_t bundle
);

	phase_t      phase_q, phase_d;
	logic [5:0]  pos_q, pos_d;
	logic [8:0]  prbs_q, prbs_d;
	logic [23:0] held_q, held_d;
	logic        seen_q, seen_d;
	logic        drop_q, drop_d;

	result_t     res [3];
	logic [1:0]  n;
	logic [8:0]  full_sat;

	assign full_sat = (32'(cfg.fullprb) > MAX_PRB_COUNT) ?
		9'(MAX_PRB_COUNT) : cfg.fullprb;

	always_comb begin
		logic [7:0] b0, b1, b2;
		logic [3:0] filt;
		logic       ok;
		logic [8:0] cnt;
		logic       do_next;
		logic       partial;
		logic [2:0] status;
		logic [5:0] posn;
		b0 = held_q[23:16];
		b1 = held_q[15:8];
		b2 = held_q[7:0];
		filt = b0[3:0];
		ok = 1'b0;
		cnt = '0;
		do_next = 1'b0;
		partial = 1'b0;
		status = ST_OK;
		posn = '0;
		phase_d = phase_q;
		pos_d = pos_q;
		prbs_d = prbs_q;
		held_d = held_q;
		seen_d = seen_q;
		drop_d = drop_q;
		n = '0;
		for (int i = 0; i < 3; i++) res[i] = '0;

		if (!drop_q) begin
			case (phase_q)
				PH_HEADER, PH_SECT: begin
					if (pos_q >= 6'd3) begin
						pos_d = '0;
						if (phase_q == PH_HEADER) begin
							ok = (b0[7] == cfg.dir) && (b0[6:4] == cfg.ver) &&
								!cfg.fmask[filt] && ({1'b0, b[5:0]} < cfg.symcnt);
							if (!ok) begin
								drop_d = 1'b1;
							end else begin
								phase_d = PH_SECT;
								res[0].kind = K_HEADER;
								res[0].frame_number = b1;
								res[0].subframe_number = b2[7:4];
								res[0].slot_number = {b2[3:0], b[7:6]};
								res[0].symbol_number = b[5:0];
								res[0].filter_number = filt;
								n = 2'd1;
							end
						end else begin
							cnt = (b == 8'd0) ? full_sat : {1'b0, b};
							res[0].kind = K_SECTHDR;
							res[0].section_number = {b0, b1[7:4]};
							res[0].section_flags = {~b1[2], ~b1[3]};
							res[0].first_prb = {b1[1:0], b2};
							res[0].prb_total = cnt;
							n = 2'd1;
							prbs_d = cnt;
							if (cfg.clen) phase_d = PH_CLEN;
							else do_next = 1'b1;
						end
					end else begin
						held_d = {held_q[15:0], b};
						pos_d = pos_q + 6'd1;
					end
				end
				PH_CLEN: begin
					if (pos_q == 6'd0) begin
						held_d = {16'd0, b};
						pos_d = 6'd1;
					end else begin
						res[0].kind = K_CLEN;
						res[0].value = {held_q[7:0], b};
						n = 2'd1;
						do_next = 1'b1;
					end
				end
				PH_PARAM: begin
					res[0].kind = K_PARAM;
					res[0].value = {8'd0, b};
					n = 2'd1;
					pos_d = '0;
					if (cfg.iqbytes == 6'd0) begin
						if (prbs_q != 9'd0) prbs_d = prbs_q - 9'd1;
						do_next = 1'b1;
					end else begin
						phase_d = PH_IQ;
					end
				end
				default: begin
					res[0].kind = K_IQ;
					res[0].value = {8'd0, b};
					n = 2'd1;
					posn = pos_q + 6'd1;
					pos_d = posn;
					if (posn >= cfg.iqbytes) begin
						if (prbs_q != 9'd0) prbs_d = prbs_q - 9'd1;
						do_next = 1'b1;
					end
				end
			endcase

			if (do_next) begin
				pos_d = '0;
				if (prbs_d != 9'd0 && cfg.cparam) begin
					phase_d = PH_PARAM;
				end else if (prbs_d != 9'd0 && cfg.iqbytes != 6'd0) begin
					phase_d = PH_IQ;
				end else begin
					prbs_d = '0;
					seen_d = 1'b1;
					phase_d = PH_SECT;
					res[n].kind = K_SDONE;
					n = n + 2'd1;
				end
			end
		end

		if (eom) begin
			partial = (phase_d != PH_SECT) || (pos_d != 6'd0);
			if (drop_d) status = ST_REJECTED;
			else if (phase_d == PH_HEADER) status = ST_SHORT;
			else if (!seen_d) status = ST_NOSECT;
			else status = partial ? ST_PARTIAL : ST_OK;
			res[n].kind = K_STATUS;
			res[n].value = {13'd0, status};
			n = n + 2'd1;
			phase_d = PH_HEADER;
			pos_d = '0;
			prbs_d = '0;
			held_d = '0;
			seen_d = 1'b0;
			drop_d = 1'b0;
		end

		if (n != 2'd0) res[n - 2'd1].last_of_run = 1'b1;
	end

	always_comb begin
		bundle = '0;
		bundle.count = in_fire ? n : 2'd0;
		bundle.r0 = res[0];
		bundle.r1 = res[1];
		bundle.r2 = res[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q <= '0;
			prbs_q <= '0;
			held_q <= '0;
			seen_q <= 1'b0;
			drop_q <= 1'b0;
		end else if (in_fire) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			prbs_q <= prbs_d;
			held_q <= held_d;
			seen_q <= seen_d;
			drop_q <= drop_d;
		end
	end

endmodule

@@ design/fud_queue.sv @@
module fud_queue
	import fud_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  bundle_t push,
	output logic    has_room,
	output logic    out_valid,
	output result_t out_data,
	input  logic    out_ready
);

	// Eight entries; a byte adds up to three results.
	logic [OUT_W-1:0] mem_q [8];
	logic [2:0] wp_q, rp_q;
	logic [3:0] cnt_q;
	logic       pop;

	assign pop = out_valid && out_ready;
	assign out_valid = cnt_q != 4'd0;
	assign out_data = result_t'(mem_q[rp_q]);
	// Room for a full three-result byte after the current cycle.
	assign has_room = cnt_q <= 4'd5;

	always_ff @(posedge clk) begin
		if (push.count >= 2'd1) mem_q[wp_q] <= push.r0;
		if (push.count >= 2'd2) mem_q[wp_q + 3'd1] <= push.r1;
		if (push.count == 2'd3) mem_q[wp_q + 3'd2] <= push.r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + {1'b0, push.count};
			if (pop) rp_q <= rp_q + 3'd1;
			cnt_q <= cnt_q + {2'd0, push.count} - {3'd0, pop};
		end
	end

endmodule

@@ design/fronthaul_uplane_deframer.sv @@
// Results are registered in an eight-entry result queue that drives the master
// side. Throughput: one byte per cycle while s_axis_tready is high; a byte can
// yield up to three results, draining one per cycle while m_axis_tready is high.
// The input stalls only while that queue holds more than five results.
// Reset (arst_n low, asynchronous) empties the queue, returns the parser to the
// header phase and loads the register reset values.
module fronthaul_uplane_deframer
	import fud_pkg::*;
#(
	parameter int MAX_PRB_COUNT = 275
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	input  logic        s_axis_tlast,  // end_of_message
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// kind, frame_number, subframe_number, slot_number, symbol_number,
	// section_number, section_flags, first_prb, prb_total, value, filter_number
	output logic [79:0] m_axis_tdata,
	output logic        m_axis_tlast,  // last_of_run
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic        dir_q, cparam_q, clen_q;
	logic [2:0]  ver_q;
	logic [15:0] fmask_q;
	logic [6:0]  symcnt_q;
	logic [8:0]  fullprb_q;
	logic [4:0]  swidth_q;
	cfg_t        cfg;
	bundle_t     bundle;
	result_t     res;
	logic        room, in_fire;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= 1'b0;
			ver_q <= 3'd1;
			fmask_q <= 16'hff00;
			symcnt_q <= 7'd14;
			fullprb_q <= 9'd273;
			swidth_q <= 5'd9;
			cparam_q <= 1'b1;
			clen_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DIR:     dir_q <= cfg_data[0];
				REG_VER:     ver_q <= cfg_data[2:0];
				REG_FMASK:   fmask_q <= cfg_data;
				REG_SYMCNT:  symcnt_q <= cfg_data[6:0];
				REG_FULLPRB: fullprb_q <= cfg_data[8:0];
				REG_SWIDTH:  swidth_q <= cfg_data[4:0];
				REG_CPARAM:  cparam_q <= cfg_data[0];
				REG_CLEN:    clen_q <= cfg_data[0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		logic [4:0] w;
		w = (swidth_q > 5'd16) ? 5'd16 : swidth_q;
		cfg.dir = dir_q;
		cfg.ver = ver_q;
		cfg.fmask = fmask_q;
		cfg.symcnt = symcnt_q;
		cfg.fullprb = fullprb_q;
		cfg.iqbytes = {1'b0, w} + {w, 1'b0};
		cfg.cparam = cparam_q;
		cfg.clen = clen_q;
	end

	assign s_axis_tready = room;
	assign in_fire = s_axis_tvalid && room;

	fud_front #(.MAX_PRB_COUNT(MAX_PRB_COUNT)) u_front (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .b(s_axis_tdata),
		.eom(s_axis_tlast), .cfg(cfg), .bundle(bundle)
	);

	fud_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(bundle), .has_room(room),
		.out_valid(m_axis_tvalid), .out_data(res), .out_ready(m_axis_tready)
	);

	assign m_axis_tdata = {res.filter_number, res.value, res.prb_total,
		res.first_prb, res.section_flags, res.section_number, res.symbol_number,
		res.slot_number, res.subframe_number, res.frame_number, res.kind};
	assign m_axis_tlast = res.last_of_run;

endmodule
